>>> sv/websocket_frame_deframer_macros.svh
// Assertion macros used by the deframer top level.
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define WSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define WSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/wsd_pkg.sv
// Shared types, codes and helpers for the WebSocket frame deframer.
package wsd_pkg;

    typedef enum logic [2:0] {
        KIND_TEXT    = 3'd0,
        KIND_BINARY  = 3'd1,
        KIND_PING    = 3'd2,
        KIND_CLOSE   = 3'd3,
        KIND_UNKNOWN = 3'd4,
        KIND_SILENT  = 3'd5
    } kind_t;

    localparam logic [3:0]  OP_CONT   = 4'h0;
    localparam logic [3:0]  OP_TEXT   = 4'h1;
    localparam logic [3:0]  OP_BINARY = 4'h2;
    localparam logic [3:0]  OP_CLOSE  = 4'h8;
    localparam logic [3:0]  OP_PING   = 4'h9;
    localparam logic [3:0]  OP_PONG   = 4'hA;

    localparam logic [6:0]  LEN_EXT16 = 7'd126;
    localparam logic [6:0]  LEN_EXT64 = 7'd127;
    localparam logic [3:0]  EXT16_BYTES = 4'd2;
    localparam logic [3:0]  EXT64_BYTES = 4'd8;
    localparam logic [3:0]  KEY_BYTES   = 4'd4;
    localparam logic [15:0] DEFAULT_CLOSE = 16'd1000;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic        has;
        logic        last;
        logic [3:0]  opcode;
        logic [15:0] status;
    } result_t;

    function automatic kind_t kind_of(input logic [3:0] op);
        kind_t k;
        unique case (op)
            OP_TEXT:          k = KIND_TEXT;
            OP_BINARY:        k = KIND_BINARY;
            OP_PING:          k = KIND_PING;
            OP_CLOSE:         k = KIND_CLOSE;
            OP_CONT, OP_PONG: k = KIND_SILENT;
            default:          k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

>>> sv/websocket_frame_deframer.sv
// Top level of the WebSocket frame deframer.
//
// Input channel: one received stream byte per request on rx_byte, handed over
// when in_valid is high and in_stall is low. Output channel: at most one result
// per input byte (frame_kind, payload_byte, has_byte, end_of_frame, raw_opcode,
// close_status), taken when out_valid is high and out_stall is low.
// Header bytes (opcode, length, extended length, masking key) give no result,
// except that the final header byte of an empty frame gives one result without
// data. Payload bytes come out unmasked and tagged; a reserved opcode gives only
// a dataless result on its last byte, and pong and continuation frames give no
// result at all. Close frames carry their status on the last result, after which
// every byte is dropped until reset. Throughput: one byte per cycle while in_stall
// is low; the parser decodes each byte with short logic between its state
// registers and the result register. Receiver stalls: the result register holds,
// a one-entry skid stage takes the next result, and in_stall rises only while
// that skid entry is occupied. Reset: asynchronous, active low; the parser waits
// for a first header byte with the session open and the output channel empty.
`include "websocket_frame_deframer_macros.svh"

module websocket_frame_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  frame_kind,
    output logic [7:0]  payload_byte,
    output logic        has_byte,
    output logic        end_of_frame,
    output logic [3:0]  raw_opcode,
    output logic [15:0] close_status
);

    logic             accept;
    logic             res_valid;
    wsd_pkg::result_t res;
    wsd_pkg::result_t out_res;
    logic             skid_full;

    // Take a request whenever the skid entry is free.
    assign in_stall = skid_full;
    assign accept   = in_valid && !in_stall;

    wsd_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    // Push only bytes that produce a result; the rest are consumed in place.
    wsd_out_skid u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && res_valid),
        .push_res  (res),
        .full      (skid_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign frame_kind   = out_res.kind;
    assign payload_byte = out_res.data;
    assign has_byte     = out_res.has;
    assign end_of_frame = out_res.last;
    assign raw_opcode   = out_res.opcode;
    assign close_status = out_res.status;

    `WSD_ASSERT_NOW(a_skid_implies_out, in_stall, out_valid, "skid entry held with empty output")
    `WSD_ASSERT_NEXT(a_push_shows, accept && res_valid, out_valid, "pushed result not presented")
    `WSD_ASSERT_NOW(a_empty_is_last, out_valid && !has_byte, end_of_frame, "dataless result not last")
    `WSD_ASSERT_NOW(a_status_on_close, out_valid && close_status != 16'd0, (frame_kind == wsd_pkg::KIND_CLOSE) && end_of_frame, "close status outside last close result")

endmodule

>>> sv/wsd_parser.sv
// Frame header parser and payload unmasker: one byte per accepted request.
module wsd_parser
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        rx_byte,
    output logic              res_valid,
    output wsd_pkg::result_t  res
);

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXTLEN,
        PH_KEY,
        PH_PAYLOAD
    } phase_t;

    phase_t         phase_reg,        phase_next;
    logic [3:0]     opcode_reg,       opcode_next;
    logic           mask_present_reg, mask_present_next;
    logic [3:0]     hdr_left_reg,     hdr_left_next;
    logic [31:0]    mask_key_reg,     mask_key_next;
    logic [63:0]    remaining_reg,    remaining_next;
    logic [1:0]     mask_pos_reg,     mask_pos_next;
    logic [15:0]    close_acc_reg,    close_acc_next;
    logic [1:0]     close_seen_reg,   close_seen_next;
    logic           session_open_reg, session_open_next;

    always_comb
    begin
        wsd_pkg::kind_t kind;
        logic [6:0]     len7;
        logic [3:0]     hdr_dec;
        logic [7:0]     key_byte;
        logic [7:0]     data;
        logic           last;
        logic           after_len;
        logic [63:0]    len_val;
        logic           hdr_done;
        logic [63:0]    hdr_rem;

        phase_next        = phase_reg;
        opcode_next       = opcode_reg;
        mask_present_next = mask_present_reg;
        hdr_left_next     = hdr_left_reg;
        mask_key_next     = mask_key_reg;
        remaining_next    = remaining_reg;
        mask_pos_next     = mask_pos_reg;
        close_acc_next    = close_acc_reg;
        close_seen_next   = close_seen_reg;
        session_open_next = session_open_reg;

        kind      = wsd_pkg::kind_of(opcode_reg);
        len7      = rx_byte[6:0];
        hdr_dec   = 4'(hdr_left_reg - 4'd1);
        after_len = 1'b0;
        len_val   = '0;
        hdr_done  = 1'b0;
        hdr_rem   = remaining_reg;
        last      = 1'b0;

        unique case (mask_pos_reg)
            2'd0:    key_byte = mask_key_reg[31:24];
            2'd1:    key_byte = mask_key_reg[23:16];
            2'd2:    key_byte = mask_key_reg[15:8];
            default: key_byte = mask_key_reg[7:0];
        endcase
        data = mask_present_reg ? (rx_byte ^ key_byte) : rx_byte;

        res_valid   = 1'b0;
        res.kind    = kind;
        res.data    = 8'd0;
        res.has     = 1'b0;
        res.last    = 1'b0;
        res.opcode  = opcode_reg;
        res.status  = 16'd0;

        if (accept && session_open_reg)
        begin
            unique case (phase_reg)
                PH_HDR0:
                begin
                    opcode_next     = rx_byte[3:0];
                    close_acc_next  = 16'd0;
                    close_seen_next = 2'd0;
                    phase_next      = PH_HDR1;
                end
                PH_HDR1:
                begin
                    mask_present_next = rx_byte[7];
                    if (len7 == wsd_pkg::LEN_EXT16 || len7 == wsd_pkg::LEN_EXT64)
                    begin
                        remaining_next = 64'd0;
                        hdr_left_next  = (len7 == wsd_pkg::LEN_EXT16) ?
                                         wsd_pkg::EXT16_BYTES : wsd_pkg::EXT64_BYTES;
                        phase_next     = PH_EXTLEN;
                    end
                    else
                    begin
                        remaining_next = {57'd0, len7};
                        after_len      = 1'b1;
                        len_val        = {57'd0, len7};
                    end
                end
                PH_EXTLEN:
                begin
                    remaining_next = {remaining_reg[55:0], rx_byte};
                    hdr_left_next  = hdr_dec;
                    if (hdr_dec == 4'd0)
                    begin
                        after_len = 1'b1;
                        len_val   = {remaining_reg[55:0], rx_byte};
                    end
                end
                PH_KEY:
                begin
                    mask_key_next = {mask_key_reg[23:0], rx_byte};
                    hdr_left_next = hdr_dec;
                    if (hdr_dec == 4'd0)
                    begin
                        hdr_done = 1'b1;
                        hdr_rem  = remaining_reg;
                    end
                end
                PH_PAYLOAD:
                begin
                    mask_pos_next  = 2'(mask_pos_reg + 2'd1);
                    remaining_next = 64'(remaining_reg - 64'd1);
                    if (kind == wsd_pkg::KIND_CLOSE && close_seen_reg < 2'd2)
                    begin
                        close_acc_next  = {close_acc_reg[7:0], data};
                        close_seen_next = 2'(close_seen_reg + 2'd1);
                    end
                    last = (remaining_reg == 64'd1);
                    if (last)
                    begin
                        phase_next = PH_HDR0;
                        if (kind == wsd_pkg::KIND_CLOSE)
                            session_open_next = 1'b0;
                    end
                    if (kind == wsd_pkg::KIND_UNKNOWN)
                    begin
                        res_valid = last;
                        res.last  = 1'b1;
                    end
                    else if (kind != wsd_pkg::KIND_SILENT)
                    begin
                        res_valid = 1'b1;
                        res.data  = data;
                        res.has   = 1'b1;
                        res.last  = last;
                        if (kind == wsd_pkg::KIND_CLOSE && last)
                            res.status = (close_seen_next >= 2'd2) ?
                                         close_acc_next : wsd_pkg::DEFAULT_CLOSE;
                    end
                end
                default:
                begin
                    phase_next = PH_HDR0;
                end
            endcase

            // Length known: fetch the masking key or close out the header.
            if (after_len)
            begin
                if (mask_present_next)
                begin
                    phase_next    = PH_KEY;
                    hdr_left_next = wsd_pkg::KEY_BYTES;
                    mask_key_next = 32'd0;
                end
                else
                begin
                    hdr_done = 1'b1;
                    hdr_rem  = len_val;
                end
            end

            // Header complete: enter payload, or finish an empty frame.
            if (hdr_done)
            begin
                mask_pos_next = 2'd0;
                if (hdr_rem != 64'd0)
                begin
                    phase_next = PH_PAYLOAD;
                end
                else
                begin
                    phase_next = PH_HDR0;
                    if (kind == wsd_pkg::KIND_CLOSE)
                        session_open_next = 1'b0;
                    if (kind != wsd_pkg::KIND_SILENT)
                    begin
                        res_valid = 1'b1;
                        res.last  = 1'b1;
                        if (kind == wsd_pkg::KIND_CLOSE)
                            res.status = (close_seen_reg >= 2'd2) ?
                                         close_acc_reg : wsd_pkg::DEFAULT_CLOSE;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HDR0;
            opcode_reg       <= 4'd0;
            mask_present_reg <= 1'b0;
            hdr_left_reg     <= 4'd0;
            mask_key_reg     <= 32'd0;
            remaining_reg    <= 64'd0;
            mask_pos_reg     <= 2'd0;
            close_acc_reg    <= 16'd0;
            close_seen_reg   <= 2'd0;
            session_open_reg <= 1'b1;
        end
        else
        begin
            phase_reg        <= phase_next;
            opcode_reg       <= opcode_next;
            mask_present_reg <= mask_present_next;
            hdr_left_reg     <= hdr_left_next;
            mask_key_reg     <= mask_key_next;
            remaining_reg    <= remaining_next;
            mask_pos_reg     <= mask_pos_next;
            close_acc_reg    <= close_acc_next;
            close_seen_reg   <= close_seen_next;
            session_open_reg <= session_open_next;
        end
    end

endmodule

>>> sv/wsd_out_skid.sv
// Result register with a one-entry skid stage toward the output channel.
module wsd_out_skid
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  wsd_pkg::result_t  push_res,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output wsd_pkg::result_t  out_res
);

    logic             out_valid_reg,  out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    wsd_pkg::result_t out_res_reg,    out_res_next;
    wsd_pkg::result_t skid_res_reg,   skid_res_next;
    logic             pop;

    assign pop = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_res_next    = out_res_reg;
        skid_res_next   = skid_res_reg;
        if (skid_valid_reg)
        begin
            // Refill the output from the skid entry once it drains.
            if (pop)
            begin
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_res_next   = push_res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_res_next   = push_res;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

>>> tb/websocket_frame_deframer_tb.sv
// Self-checking testbench for the WebSocket frame deframer.
module websocket_frame_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wsd_pkg::*;

    // Flag nibbles for the first header byte (FIN plus the reserved bits).
    localparam logic [3:0] FLAGS_NONE = 4'h0;
    localparam logic [3:0] FLAGS_FIN  = 4'h8;
    localparam logic [3:0] FLAGS_ALL  = 4'hF;

    // Opcodes the package leaves unnamed: reserved data and reserved control ranges.
    localparam logic [3:0] OP_DATA_RSV_FIRST = 4'h3;
    localparam logic [3:0] OP_CTRL_RSV_FIRST = 4'hB;
    localparam logic [3:0] OP_CTRL_RSV_LAST  = 4'hF;

    localparam int STREAM_TARGET = 830;   // stream bytes before the closing frame
    localparam int QUIET_LIMIT   = 2000;  // cycles with no handshake before giving up

    localparam result_t NO_RESULT = '0;

    typedef enum logic [2:0] {
        STG_OPCODE,
        STG_LENGTH,
        STG_EXTLEN,
        STG_KEY,
        STG_PAYLOAD
    } parse_stage_t;

    typedef enum int {
        LEN_SHORT_FORM,
        LEN_16_FORM,
        LEN_64_FORM
    } len_form_t;

    typedef enum int {
        CLOSE_EMPTY,
        CLOSE_ONE_BYTE,
        CLOSE_WITH_CODE,
        CLOSE_ENDLESS
    } close_plan_t;

    // One row of the directed table: the stream byte and, where it is obvious,
    // the result that byte must produce.
    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        result_t    want;
    } stim_row_t;

    localparam int DIR_ROWS = 26;
    localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
        // Empty unmasked text frame: a single dataless result right after the length byte.
        '{{FLAGS_FIN, OP_TEXT}, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, '{KIND_TEXT, 8'h00, 1'b0, 1'b1, OP_TEXT, 16'h0000}},
        // Empty masked binary frame: the result waits for the last key byte.
        '{{FLAGS_FIN, OP_BINARY}, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'hFF, 1'b1, '{KIND_BINARY, 8'h00, 1'b0, 1'b1, OP_BINARY, 16'h0000}},
        // One-byte unmasked ping: the byte passes through untouched.
        '{{FLAGS_FIN, OP_PING}, 1'b0, NO_RESULT},
        '{8'h01, 1'b0, NO_RESULT},
        '{8'hFF, 1'b1, '{KIND_PING, 8'hFF, 1'b1, 1'b1, OP_PING, 16'h0000}},
        // Pong with no FIN: swallowed without a result.
        '{{FLAGS_NONE, OP_PONG}, 1'b0, NO_RESULT},
        '{8'h01, 1'b0, NO_RESULT},
        '{8'h5A, 1'b0, NO_RESULT},
        // Reserved data opcode with every flag bit set, empty payload.
        '{{FLAGS_ALL, OP_DATA_RSV_FIRST}, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, '{KIND_UNKNOWN, 8'h00, 1'b0, 1'b1, OP_DATA_RSV_FIRST, 16'h0000}},
        // Reserved control opcode, masked, 16-bit length of two: error on the last byte.
        '{{FLAGS_FIN, OP_CTRL_RSV_LAST}, 1'b0, NO_RESULT},
        '{{1'b1, LEN_EXT16}, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h02, 1'b0, NO_RESULT},
        '{8'h12, 1'b0, NO_RESULT},
        '{8'h34, 1'b0, NO_RESULT},
        '{8'h56, 1'b0, NO_RESULT},
        '{8'h78, 1'b0, NO_RESULT},
        '{8'hAA, 1'b0, NO_RESULT},
        '{8'h55, 1'b1, '{KIND_UNKNOWN, 8'h00, 1'b0, 1'b1, OP_CTRL_RSV_LAST, 16'h0000}}
    };

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  frame_kind;
    logic [7:0]  payload_byte;
    logic        has_byte;
    logic        end_of_frame;
    logic [3:0]  raw_opcode;
    logic [15:0] close_status;

    websocket_frame_deframer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_kind   (frame_kind),
        .payload_byte (payload_byte),
        .has_byte     (has_byte),
        .end_of_frame (end_of_frame),
        .raw_opcode   (raw_opcode),
        .close_status (close_status)
    );

    // Results the deframer still owes us, oldest first.
    result_t pending_results [$];

    int stream_bytes = 0;
    int frames_sent  = 0;
    int results_seen = 0;
    int error_count  = 0;
    bit calm         = 1'b0;   // when set, neither side idles nor stalls

    // Deframer state as this testbench tracks it.
    parse_stage_t stage        = STG_OPCODE;
    logic [3:0]   cur_op       = '0;
    logic         masked_frame = 1'b0;
    logic [3:0]   hdr_left     = '0;
    logic [31:0]  mask_word    = '0;
    logic [63:0]  bytes_left   = '0;
    logic [1:0]   key_pos      = '0;
    logic [15:0]  status_acc   = '0;
    logic [1:0]   status_cnt   = '0;
    bit           link_open    = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Deframing predictor
    // ------------------------------------------------------------------

    // Map the opcode nibble onto the kind it is reported as.
    function automatic kind_t classify(input logic [3:0] op);
        case (op)
            OP_TEXT:          return KIND_TEXT;
            OP_BINARY:        return KIND_BINARY;
            OP_PING:          return KIND_PING;
            OP_CLOSE:         return KIND_CLOSE;
            OP_CONT, OP_PONG: return KIND_SILENT;
            default:          return KIND_UNKNOWN;
        endcase
    endfunction

    // Build a result; the close status rides only on the last close result.
    function automatic result_t make_result(input kind_t k, input logic [7:0] d,
                                            input logic has, input logic last);
        result_t r;
        r.kind   = k;
        r.data   = has ? d : 8'h00;
        r.has    = has;
        r.last   = last;
        r.opcode = cur_op;
        if (k == KIND_CLOSE && last)
            r.status = (status_cnt >= 2) ? status_acc : DEFAULT_CLOSE;
        else
            r.status = '0;
        return r;
    endfunction

    // Return to the first header byte; a finished close shuts the link for good.
    function automatic void end_of_message(input kind_t k);
        stage = STG_OPCODE;
        if (k == KIND_CLOSE)
            link_open = 1'b0;
    endfunction

    // Header complete: enter the payload, or report an empty frame now.
    function automatic bit finish_header(output result_t r);
        kind_t k;
        k = classify(cur_op);
        r = NO_RESULT;
        key_pos = '0;
        if (bytes_left != 0)
        begin
            stage = STG_PAYLOAD;
            return 1'b0;
        end
        end_of_message(k);
        if (k == KIND_SILENT)
            return 1'b0;
        r = make_result(k, 8'h00, 1'b0, 1'b1);
        return 1'b1;
    endfunction

    // Length known: collect the key first if the frame is masked.
    function automatic bit finish_length(output result_t r);
        r = NO_RESULT;
        if (masked_frame)
        begin
            stage     = STG_KEY;
            hdr_left  = KEY_BYTES;
            mask_word = '0;
            return 1'b0;
        end
        return finish_header(r);
    endfunction

    // Advance the tracked parser by one stream byte; return 1 if a result is due.
    function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
        kind_t      k;
        logic [7:0] d;
        logic       last;
        r = NO_RESULT;
        if (!link_open)
            return 1'b0;
        k = classify(cur_op);
        case (stage)
            STG_OPCODE:
            begin
                cur_op     = b[3:0];
                status_acc = '0;
                status_cnt = '0;
                stage      = STG_LENGTH;
                return 1'b0;
            end
            STG_LENGTH:
            begin
                masked_frame = b[7];
                bytes_left   = '0;
                if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64)
                begin
                    hdr_left = (b[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                    stage    = STG_EXTLEN;
                    return 1'b0;
                end
                bytes_left = 64'(b[6:0]);
                return finish_length(r);
            end
            STG_EXTLEN:
            begin
                bytes_left = {bytes_left[55:0], b};
                hdr_left   = hdr_left - 4'd1;
                if (hdr_left != 0)
                    return 1'b0;
                return finish_length(r);
            end
            STG_KEY:
            begin
                mask_word = {mask_word[23:0], b};
                hdr_left  = hdr_left - 4'd1;
                if (hdr_left != 0)
                    return 1'b0;
                return finish_header(r);
            end
            default:
            begin
                // Unmask with the key byte at the current position, then advance it.
                d = masked_frame ? (b ^ mask_word[8 * (3 - int'(key_pos)) +: 8]) : b;
                key_pos    = key_pos + 2'd1;
                bytes_left = bytes_left - 64'd1;
                if (k == KIND_CLOSE && status_cnt < 2)
                begin
                    status_acc = {status_acc[7:0], d};
                    status_cnt = status_cnt + 2'd1;
                end
                last = (bytes_left == 0);
                if (last)
                    end_of_message(k);
                if (k == KIND_SILENT)
                    return 1'b0;
                if (k == KIND_UNKNOWN)
                begin
                    if (!last)
                        return 1'b0;
                    r = make_result(k, 8'h00, 1'b0, 1'b1);
                    return 1'b1;
                end
                r = make_result(k, d, 1'b1, last);
                return 1'b1;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one stream byte, idling at random first, and hold it until the
    // request is taken. A typed expectation replaces the predicted one.
    task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input result_t want = NO_RESULT);
        result_t predicted;
        bit      due;
        while (!calm && $urandom_range(99) < 36)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        stream_bytes++;
        due = deframe_byte(b, predicted);
        if (typed)
            pending_results.push_back(want);
        else if (due)
            pending_results.push_back(predicted);
    endtask

    // Send a whole frame; cap limits how much of a long payload actually goes out.
    task automatic send_frame(input logic [3:0] op, input logic [63:0] len,
                              input len_form_t form, input bit masked,
                              input logic [63:0] cap);
        logic [31:0] key;
        logic [63:0] n;
        key = $urandom;
        send_byte({4'($urandom_range(15)), op});
        case (form)
            LEN_SHORT_FORM:
                send_byte({masked, len[6:0]});
            LEN_16_FORM:
            begin
                send_byte({masked, LEN_EXT16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            default:
            begin
                send_byte({masked, LEN_EXT64});
                for (int i = 7; i >= 0; i--)
                    send_byte(len[8 * i +: 8]);
            end
        endcase
        if (masked)
            for (int i = 3; i >= 0; i--)
                send_byte(key[8 * i +: 8]);
        for (n = 0; n < len && n < cap; n++)
            send_byte(8'($urandom_range(255)));
        frames_sent++;
    endtask

    // Drop valid and hold off until every owed result
    // has been taken.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // Stall the result channel about a third of the time, except in calm stretches.
    always @(posedge clk)
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < 36);

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t ns: %s mismatch: expected %0h, actual %0h",
                     $time, name, want, got);
        end
    endfunction

    // Compare every taken result against the oldest expectation, field by field.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t ns: unexpected result: expected none, actual kind %0d byte %02h",
                         $time, frame_kind, payload_byte);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("frame_kind", 16'(want.kind), 16'(frame_kind));
                check_field("payload_byte", 16'(want.data), 16'(payload_byte));
                check_field("has_byte", 16'(want.has), 16'(has_byte));
                check_field("end_of_frame", 16'(want.last), 16'(end_of_frame));
                check_field("raw_opcode", 16'(want.opcode), 16'(raw_opcode));
                check_field("close_status", want.status, close_status);
                results_seen++;
            end
        end
    end

    // Watchdog: give up once no request moves on either side for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        logic [3:0]  op;
        logic [63:0] len;
        len_form_t   form;
        close_plan_t plan;
        int          pick;
        bit          paused;
        paused = 1'b0;

        // Hold reset low from the start, then release it once.
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table.
        for (int i = 0; i < DIR_ROWS; i++)
            send_byte(DIR_TABLE[i].rx, DIR_TABLE[i].typed, DIR_TABLE[i].want);
        drain_results();

        // Random frames: mostly data and ping, some silent ones, three in ten with
        // reserved opcodes; flag bits are always random.
        while (stream_bytes < STREAM_TARGET)
        begin
            calm <= (stream_bytes >= 450 && stream_bytes < 600);
            if (!paused && stream_bytes >= 300)
            begin
                drain_results();
                paused = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 20)
                op = OP_TEXT;
            else if (pick < 40)
                op = OP_BINARY;
            else if (pick < 55)
                op = OP_PING;
            else if (pick < 63)
                op = OP_PONG;
            else if (pick < 70)
                op = OP_CONT;
            else
            begin
                pick = $urandom_range(9);
                op = (pick < 5) ? OP_DATA_RSV_FIRST + 4'(pick)
                                : OP_CTRL_RSV_FIRST + 4'(pick - 5);
            end
            pick = $urandom_range(99);
            if (pick < 65)
            begin
                len  = 64'($urandom_range(12));
                form = LEN_SHORT_FORM;
            end
            else if (pick < 75)
            begin
                len  = 64'($urandom_range(125, 13));
                form = LEN_SHORT_FORM;
            end
            else
            begin
                len  = 64'($urandom_range(300));
                form = (pick < 88) ? LEN_16_FORM : LEN_64_FORM;
            end
            send_frame(op, len, form, 1'($urandom_range(1)), len);
        end
        calm <= 1'b0;

        // Close the session. The endless variant carries a length with its top
        // bit set, so its payload never ends and the link stays open.
        plan = close_plan_t'($urandom_range(3));
        case (plan)
            CLOSE_EMPTY:
                send_frame(OP_CLOSE, 64'd0, LEN_SHORT_FORM, 1'($urandom_range(1)), 64'd0);
            CLOSE_ONE_BYTE:
                send_frame(OP_CLOSE, 64'd1, LEN_SHORT_FORM, 1'($urandom_range(1)), 64'd1);
            CLOSE_WITH_CODE:
            begin
                len = 64'($urandom_range(10, 2));
                send_frame(OP_CLOSE, len, LEN_SHORT_FORM, 1'($urandom_range(1)), len);
            end
            default:
            begin
                len = {1'b1, 31'($urandom), 32'($urandom)};
                send_frame(OP_CLOSE, len, LEN_64_FORM, 1'b1, 64'd24);
            end
        endcase

        // Trailing bytes: dropped once the session is closed.
        repeat (16)
            send_byte(8'($urandom_range(255)));

        drain_results();
        repeat (8) @(posedge clk);

        $display("Covered %0d stream bytes in %0d frames plus the directed table;",
                 stream_bytes, frames_sent);
        $display("compared %0d results; closing variant %s.", results_seen, plan.name());
        if (error_count == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
